>>> rtl/ptt_pkg.sv
// Package for the periodic timer table: payload structs, codes and the
// controller/datapath command and status structs. No dependencies.
`default_nettype none
package ptt_pkg;
   localparam int NumTimers = 16;
   localparam int SlotW = $clog2(NumTimers);

   localparam logic [1:0] ModeAdd = 2'd0;
   localparam logic [1:0] ModeRemove = 2'd1;
   localparam logic [1:0] ModeTick = 2'd2;
   localparam logic [1:0] ModeUnused = 2'd3;

   localparam logic [1:0] KindAdd = 2'd0;
   localparam logic [1:0] KindRemove = 2'd1;
   localparam logic [1:0] KindExpiry = 2'd2;

   localparam logic [1:0] StatusOk = 2'd0;
   localparam logic [1:0] StatusFull = 2'd1;
   localparam logic [1:0] StatusNotFound = 2'd2;

   typedef struct packed {
      logic [1:0] mode;
      logic [23:0] period_ms;
      logic [15:0] target_handle;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [15:0] result_handle;
      logic [1:0] status;
      logic last;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;        // latch request, advance time on tick
      logic scan;        // examine slot at scan index
      logic [SlotW-1:0] idx;
      logic add_write;   // write free slot found by scan
      logic remove_hit;  // clear matched slot
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic valid;       // slot at idx is valid
      logic match;       // slot at idx holds target handle
      logic due;         // slot at idx is due
   } sts_type;
endpackage
`default_nettype wire

>>> rtl/periodic_timer_table.sv
// Top level of the periodic timer table: controller plus datapath.
// Depends on ptt_pkg, ptt_controller, ptt_datapath.
//
// channel    ports                        handshake
// request    req_payload                  start && !busy
// response   rsp_payload                  rsp_strobe (one cycle, no stall)
//
// One slot of the table is examined per cycle by the controller's scan
// counter: add and remove stop at the first hit, a tick walks all 16 slots
// and then drains the one held expiry, if any.
// The unused mode is dropped in its accept cycle.
// Reset clears the valid bits, time to zero and the handle counter to one.
// The receiver cannot stall; responses leave once per strobe.
`default_nettype none
module periodic_timer_table (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic busy,
   input  wire ptt_pkg::req_type req_payload,
   output logic rsp_strobe,
   output ptt_pkg::rsp_type rsp_payload
);
   ptt_pkg::cmd_type cmd;
   ptt_pkg::sts_type sts;
   logic [15:0] handle;
   logic [15:0] next_handle;

   // sequence the scan and build each transaction's responses
   ptt_controller u_ctrl (
      .clock(clock), .reset(reset), .start(start),
      .mode_in(req_payload.mode), .target_in(req_payload.target_handle),
      .sts(sts), .handle_in(handle), .next_handle_in(next_handle),
      .cmd(cmd), .busy(busy), .rsp_strobe(rsp_strobe), .rsp(rsp_payload)
   );

   // hold the slot table, the time and the handle counter
   ptt_datapath u_dp (
      .clock(clock), .reset(reset), .req_in(req_payload), .cmd(cmd),
      .sts(sts), .handle_out(handle), .next_handle_out(next_handle)
   );
endmodule
`default_nettype wire

>>> rtl/ptt_datapath.sv
// Datapath of the periodic timer table: slot store, time and handle counters.
// Depends on ptt_pkg.
`default_nettype none
module ptt_datapath (
   input  wire logic clock,
   input  wire logic reset,
   input  wire ptt_pkg::req_type req_in,
   input  wire ptt_pkg::cmd_type cmd,
   output ptt_pkg::sts_type sts,
   output logic [15:0] handle_out,
   output logic [15:0] next_handle_out
);
   logic [ptt_pkg::NumTimers-1:0] valid_ff;
   logic [15:0] handle_ff [ptt_pkg::NumTimers];
   logic [23:0] period_ff [ptt_pkg::NumTimers];
   logic [31:0] deadline_ff [ptt_pkg::NumTimers];
   logic [31:0] time_ff;
   logic [15:0] next_handle_ff;
   ptt_pkg::req_type req_ff;
   logic [31:0] diff;

   assign diff = time_ff - deadline_ff[cmd.idx];
   assign sts.valid = valid_ff[cmd.idx];
   assign sts.match = valid_ff[cmd.idx] && handle_ff[cmd.idx] == req_ff.target_handle;
   assign sts.due = valid_ff[cmd.idx] && !diff[31];
   assign handle_out = handle_ff[cmd.idx];
   assign next_handle_out = next_handle_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_in;
      if (cmd.add_write) begin
         handle_ff[cmd.idx] <= next_handle_ff;
         period_ff[cmd.idx] <= req_ff.period_ms;
         deadline_ff[cmd.idx] <= time_ff + {8'd0, req_ff.period_ms};
      end else if (cmd.scan && req_ff.mode == ptt_pkg::ModeTick && sts.due) begin
         deadline_ff[cmd.idx] <= time_ff + {8'd0, period_ff[cmd.idx]};
      end
      if (reset) begin
         valid_ff <= '0;
         time_ff <= '0;
         next_handle_ff <= 16'd1;
      end else begin
         if (cmd.load && req_in.mode == ptt_pkg::ModeTick) time_ff <= time_ff + 32'd1;
         if (cmd.add_write) begin
            valid_ff[cmd.idx] <= 1'b1;
            next_handle_ff <= (next_handle_ff == 16'hFFFF) ? 16'd1 : next_handle_ff + 16'd1;
         end
         if (cmd.remove_hit) valid_ff[cmd.idx] <= 1'b0;
      end
   end
endmodule
`default_nettype wire

>>> rtl/ptt_controller.sv
// Controller of the periodic timer table: slot scan sequencer and response
// formatting. Depends on ptt_pkg.
`default_nettype none
module ptt_controller (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic [1:0] mode_in,
   input  wire logic [15:0] target_in,
   input  wire ptt_pkg::sts_type sts,
   input  wire logic [15:0] handle_in,
   input  wire logic [15:0] next_handle_in,
   output ptt_pkg::cmd_type cmd,
   output logic busy,
   output logic rsp_strobe,
   output ptt_pkg::rsp_type rsp
);
   typedef enum logic [1:0] {Idle, Scan, Flush} state_type;
   state_type state_ff;
   logic [1:0] mode_ff;
   logic [15:0] target_ff;
   logic [ptt_pkg::SlotW-1:0] idx_ff;
   logic last_slot;
   // one expiry is held back so that its last flag can be set at scan end
   logic pend_ff;
   ptt_pkg::rsp_type pend_rsp_ff;
   logic strobe_ff;
   ptt_pkg::rsp_type rsp_ff;

   assign last_slot = idx_ff == ptt_pkg::SlotW'(ptt_pkg::NumTimers - 1);
   assign busy = state_ff != Idle;
   assign rsp_strobe = strobe_ff;
   assign rsp = rsp_ff;

   always_comb begin
      cmd.load = start && state_ff == Idle;
      cmd.scan = state_ff == Scan;
      cmd.idx = idx_ff;
      cmd.add_write = state_ff == Scan && mode_ff == ptt_pkg::ModeAdd && !sts.valid;
      cmd.remove_hit = state_ff == Scan && mode_ff == ptt_pkg::ModeRemove && sts.match;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= Idle;
         pend_ff <= 1'b0;
         idx_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         case (state_ff)
            Idle: begin
               idx_ff <= '0;
               pend_ff <= 1'b0;
               strobe_ff <= 1'b0;
               if (start) begin
                  mode_ff <= mode_in;
                  target_ff <= target_in;
                  state_ff <= (mode_in == ptt_pkg::ModeUnused) ? Idle : Scan;
               end
            end
            Scan: begin
               idx_ff <= idx_ff + ptt_pkg::SlotW'(1);
               if (cmd.add_write) begin
                  strobe_ff <= 1'b1;
                  rsp_ff <= '{ptt_pkg::KindAdd, next_handle_in, ptt_pkg::StatusOk, 1'b1};
                  state_ff <= Idle;
               end else if (cmd.remove_hit) begin
                  strobe_ff <= 1'b1;
                  rsp_ff <= '{ptt_pkg::KindRemove, target_ff, ptt_pkg::StatusOk, 1'b1};
                  state_ff <= Idle;
               end else if (mode_ff == ptt_pkg::ModeTick) begin
                  strobe_ff <= sts.due && pend_ff;
                  if (sts.due) begin
                     if (pend_ff) rsp_ff <= pend_rsp_ff;
                     pend_ff <= 1'b1;
                     pend_rsp_ff <= '{ptt_pkg::KindExpiry, handle_in, ptt_pkg::StatusOk, 1'b0};
                  end
                  if (last_slot) state_ff <= Flush;
               end else if (last_slot) begin
                  strobe_ff <= 1'b1;
                  if (mode_ff == ptt_pkg::ModeAdd)
                     rsp_ff <= '{ptt_pkg::KindAdd, 16'd0, ptt_pkg::StatusFull, 1'b1};
                  else
                     rsp_ff <= '{ptt_pkg::KindRemove, 16'd0, ptt_pkg::StatusNotFound, 1'b1};
                  state_ff <= Idle;
               end else begin
                  strobe_ff <= 1'b0;
               end
            end
            Flush: begin
               strobe_ff <= pend_ff;
               if (pend_ff)
                  rsp_ff <= '{pend_rsp_ff.kind, pend_rsp_ff.result_handle,
                              pend_rsp_ff.status, 1'b1};
               pend_ff <= 1'b0;
               state_ff <= Idle;
            end
            default: begin
               strobe_ff <= 1'b0;
               state_ff <= Idle;
            end
         endcase
      end
   end
endmodule
`default_nettype wire

>>> rtl/ptt_checker.sv
// Port checker for the periodic timer table, bound to the top level.
// Depends on ptt_pkg.
`default_nettype none
module ptt_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic busy,
   input wire logic rsp_strobe,
   input wire ptt_pkg::rsp_type rsp_payload
);
   a_idle_after_reset: assert property (@(posedge clock) reset |=> !busy && !rsp_strobe)
      else $error("busy or strobe after reset");
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_payload.last |-> busy) else $error("non-last response while idle");
   a_kind_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_payload.kind == ptt_pkg::KindAdd ||
                      rsp_payload.kind == ptt_pkg::KindRemove ||
                      rsp_payload.kind == ptt_pkg::KindExpiry))
      else $error("bad kind");
   a_expiry_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_payload.kind == ptt_pkg::KindExpiry
         |-> rsp_payload.status == ptt_pkg::StatusOk)
      else $error("expiry with bad status");
endmodule

bind periodic_timer_table ptt_checker u_chk (
   .clock(clock), .reset(reset), .busy(busy),
   .rsp_strobe(rsp_strobe), .rsp_payload(rsp_payload)
);
`default_nettype wire

>>> bench/periodic_timer_table_tb.sv
// Self-checking bench for periodic_timer_table: directed and random add, remove
// and tick transactions checked against a behavioral timer table in a scoreboard.
// Depends on ptt_pkg and the periodic_timer_table RTL.
`timescale 1ns / 1ps
`default_nettype none

module periodic_timer_table_tb;

   localparam int MaxCycles = 400000;

   // Behavioral timer table plus the queue of pending responses.
   class timer_scoreboard;
      bit         live[ptt_pkg::NumTimers];
      bit [15:0]  handle_of[ptt_pkg::NumTimers];
      bit [23:0]  period_of[ptt_pkg::NumTimers];
      bit [31:0]  deadline_of[ptt_pkg::NumTimers];
      bit [31:0]  now_ms;
      bit [15:0]  handle_next;
      ptt_pkg::rsp_type pending[$];
      int         mismatches;

      function new();
         for (int i = 0; i < ptt_pkg::NumTimers; i++) live[i] = 0;
         now_ms = 0;
         handle_next = 1;
         mismatches = 0;
      endfunction

      // Predict the responses for one accepted transaction.
      function void note_request(ptt_pkg::req_type rq);
         ptt_pkg::rsp_type r;
         int n;
         bit done;
         r = '0;
         done = 0;
         n = 0;
         case (rq.mode)
            ptt_pkg::ModeAdd: begin
               for (int i = 0; i < ptt_pkg::NumTimers && !done; i++) begin
                  if (!live[i]) begin
                     live[i] = 1;
                     handle_of[i] = handle_next;
                     period_of[i] = rq.period_ms;
                     deadline_of[i] = now_ms + {8'd0, rq.period_ms};
                     r.result_handle = handle_next;
                     handle_next = (handle_next == 16'hFFFF) ? 16'd1 : handle_next + 16'd1;
                     done = 1;
                  end
               end
               r.kind = ptt_pkg::KindAdd;
               r.status = done ? ptt_pkg::StatusOk : ptt_pkg::StatusFull;
               r.last = 1;
               pending = {pending, r};
            end
            ptt_pkg::ModeRemove: begin
               for (int i = 0; i < ptt_pkg::NumTimers && !done; i++) begin
                  if (live[i] && handle_of[i] == rq.target_handle) begin
                     live[i] = 0;
                     done = 1;
                  end
               end
               r.kind = ptt_pkg::KindRemove;
               r.result_handle = done ? rq.target_handle : 16'd0;
               r.status = done ? ptt_pkg::StatusOk : ptt_pkg::StatusNotFound;
               r.last = 1;
               pending = {pending, r};
            end
            ptt_pkg::ModeTick: begin
               now_ms = now_ms + 32'd1;
               for (int i = 0; i < ptt_pkg::NumTimers; i++) begin
                  bit [31:0] lag;
                  lag = now_ms - deadline_of[i];
                  if (live[i] && !lag[31]) begin
                     deadline_of[i] = now_ms + {8'd0, period_of[i]};
                     r.kind = ptt_pkg::KindExpiry;
                     r.result_handle = handle_of[i];
                     r.status = ptt_pkg::StatusOk;
                     r.last = 0;
                     pending = {pending, r};
                     n++;
                  end
               end
               // flag the final expiry of this tick
               if (n > 0) pending[pending.size() - 1].last = 1;
            end
            default: ;
         endcase
      endfunction

      function void check_response(ptt_pkg::rsp_type got);
         ptt_pkg::rsp_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response kind=%0d handle=%0d status=%0d last=%0d",
                        got.kind, got.result_handle, got.status, got.last);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"mismatch: exp kind=%0d handle=%0d status=%0d last=%0d,",
                         " got kind=%0d handle=%0d status=%0d last=%0d"},
                        want.kind, want.result_handle, want.status, want.last,
                        got.kind, got.result_handle, got.status, got.last);
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   ptt_pkg::req_type req_payload;
   logic    rsp_strobe;
   ptt_pkg::rsp_type rsp_payload;

   timer_scoreboard sb;
   int idle_pct;
   int cycle_count = 0;

   periodic_timer_table u_top (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // Note accepted transactions and check responses at the rising edge.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (start && !busy) sb.note_request(req_payload);
         if (rsp_strobe) sb.check_response(rsp_payload);
      end
   end

   // Timeout guard.
   always @(posedge clock) begin
      if (cycle_count > MaxCycles) begin
         $display("[periodic_timer_table] ERROR");
         $finish;
      end
   end

   // Issue one transaction: optional idle gap, hold start until accepted.
   task automatic send(input logic [1:0] mode, input logic [23:0] period,
                       input logic [15:0] target);
      while ($urandom_range(99) < idle_pct) @(negedge clock);
      start = 1;
      req_payload.mode = mode;
      req_payload.period_ms = period;
      req_payload.target_handle = target;
      do @(posedge clock); while (busy);
      @(negedge clock);
      start = 0;
   endtask

   // Random transaction: mostly ticks, with adds, removes (mostly of recent handles) and rare unused requests.
   task automatic send_random();
      int sel;
      logic [23:0] p;
      sel = $urandom_range(99);
      if (sel < 30) begin
         case ($urandom_range(3))
            0: p = 24'($urandom_range(1, 4));
            1: p = 24'($urandom_range(1, 40));
            2: p = 24'($urandom);
            default: p = 24'($urandom_range(0, 1));
         endcase
         send(ptt_pkg::ModeAdd, p, 16'($urandom));
      end else if (sel < 45) begin
         if ($urandom_range(3) == 0)
            send(ptt_pkg::ModeRemove, 24'($urandom), 16'($urandom));
         else
            send(ptt_pkg::ModeRemove, 24'($urandom),
                 16'(sb.handle_next - 16'($urandom_range(1, 20))));
      end else if (sel < 97) begin
         send(ptt_pkg::ModeTick, 24'($urandom), 16'($urandom));
      end else begin
         send(ptt_pkg::ModeUnused, 24'($urandom), 16'($urandom));
      end
   endtask

   task automatic drain();
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   initial begin
      sb = new();
      idle_pct = 10;
      reset = 1;
      start = 0;
      req_payload = '0;
      repeat (10) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // Directed: extremes of period, removes that miss, unused mode.
      send(ptt_pkg::ModeRemove, 24'd0, 16'd0);
      send(ptt_pkg::ModeRemove, 24'hFFFFFF, 16'hFFFF);
      send(ptt_pkg::ModeAdd, 24'd0, 16'd0);           // zero period fires every tick
      send(ptt_pkg::ModeAdd, 24'd1, 16'hFFFF);
      send(ptt_pkg::ModeAdd, 24'hFFFFFF, 16'd0);
      send(ptt_pkg::ModeAdd, 24'h800000, 16'd0);
      send(ptt_pkg::ModeUnused, 24'hFFFFFF, 16'hFFFF);
      send(ptt_pkg::ModeTick, 24'd0, 16'd0);
      send(ptt_pkg::ModeTick, 24'hFFFFFF, 16'hFFFF);
      send(ptt_pkg::ModeRemove, 24'd0, 16'd2);
      // fill the table, then overflow it
      for (int i = 0; i < 14; i++) send(ptt_pkg::ModeAdd, 24'd1, 16'd0);
      send(ptt_pkg::ModeAdd, 24'd3, 16'd0);           // table full
      send(ptt_pkg::ModeTick, 24'd0, 16'd0);          // fourteen expiries
      send(ptt_pkg::ModeRemove, 24'd0, 16'd1);
      drain();

      // Random, three idling phases.
      for (int ph = 0; ph < 3; ph++) begin
         idle_pct = (ph == 0) ? 10 : ((ph == 1) ? 51 : 0);
         for (int k = 0; k < 105; k++) send_random();
         drain();
      end

      idle_pct = 0;
      for (int k = 0; k < 30; k++) send_random();
      drain();

      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("[periodic_timer_table] OK");
      end else begin
         $display("[periodic_timer_table] ERROR");
      end
      $finish;
   end
endmodule

`default_nettype wire

>>> sim.f
rtl/ptt_pkg.sv
rtl/ptt_datapath.sv
rtl/ptt_controller.sv
rtl/periodic_timer_table.sv
rtl/ptt_checker.sv
bench/periodic_timer_table_tb.sv
